@@ sv/lbas_pkg.sv @@
// Shared types and constants for the line bounded access splitter.
// Used by lbas_front, lbas_queue, lbas_back and line_bounded_access_splitter.
package lbas_pkg;

	localparam int unsigned LINE_BYTES_DEF       = 64;
	localparam int unsigned MAX_ACCESS_BYTES_DEF = 64;
	localparam int unsigned QUEUE_DEPTH          = 2;

	localparam int unsigned THREAD_W = 8;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned SEQ_W    = 64;
	localparam int unsigned PIECE_W  = 4;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic [THREAD_W-1:0] thread;
		logic                kind;
		logic [ADDR_W-1:0]   address;
		logic [SIZE_W-1:0]   size;
	} access_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_status_t;

endpackage

@@ sv/line_bounded_access_splitter.sv @@
// Splits a memory access into pieces of 8, 4, 2 or 1 bytes that never cross a
// line of LINE_BYTES bytes (a power of two) and emits one result per piece with a
// running sequence number; sizes above MAX_ACCESS_BYTES are clamped, a zero size
// gives no result. The back end emits one piece per clock while the receiver does
// not stall, and the next access from the two-entry queue starts right after the
// last piece of the previous one. The single piece selector and address adder in
// the back end set that rate; the first result passes through the queue, the back
// end's access registers and the result register.
module line_bounded_access_splitter #(
	parameter int unsigned LINE_BYTES       = lbas_pkg::LINE_BYTES_DEF,
	parameter int unsigned MAX_ACCESS_BYTES = lbas_pkg::MAX_ACCESS_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lbas_pkg::THREAD_W-1:0] thread,
	input  logic                          kind,
	input  logic [lbas_pkg::ADDR_W-1:0]   address,
	input  logic [lbas_pkg::SIZE_W-1:0]   size,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [lbas_pkg::SEQ_W-1:0]    sequence_res,
	output logic [lbas_pkg::THREAD_W-1:0] thread_out,
	output logic                          kind_out,
	output logic [lbas_pkg::ADDR_W-1:0]   piece_address,
	output logic                          last
);

	logic                   push;
	lbas_pkg::access_t      push_data;
	logic                   queue_full;
	logic                   queue_not_empty;
	lbas_pkg::access_t      head;
	lbas_pkg::back_status_t status;
	logic [$clog2(lbas_pkg::QUEUE_DEPTH+1)-1:0] level;

	lbas_front #(
		.MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.thread    (thread),
		.kind      (kind),
		.address   (address),
		.size      (size),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	lbas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (status.pop),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.head     (head),
		.level    (level)
	);

	lbas_back #(
		.LINE_BYTES(LINE_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (queue_not_empty),
		.head         (head),
		.status       (status),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.sequence_res (sequence_res),
		.thread_out   (thread_out),
		.kind_out     (kind_out),
		.piece_address(piece_address),
		.last         (last)
	);

`ifndef NO_ASSERTIONS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(lbas_pkg::QUEUE_DEPTH+1))'(lbas_pkg::QUEUE_DEPTH))
		else $error("queue level above depth");

	a_no_empty_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.size != '0))
		else $error("empty access entered queue");

	a_more_pieces: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last) |=> (res_valid || status.busy))
		else $error("access ended without a last piece");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> (level != '0))
		else $error("pop from empty queue");
`endif

endmodule

@@ sv/lbas_front.sv @@
// Front end: takes requests, clamps the size and drops empty accesses.
// Depends on lbas_pkg.
module lbas_front #(
	parameter int unsigned MAX_ACCESS_BYTES = lbas_pkg::MAX_ACCESS_BYTES_DEF
) (
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lbas_pkg::THREAD_W-1:0] thread,
	input  logic                          kind,
	input  logic [lbas_pkg::ADDR_W-1:0]   address,
	input  logic [lbas_pkg::SIZE_W-1:0]   size,
	input  logic                          queue_full,
	output logic                          push,
	output lbas_pkg::access_t             push_data
);

	localparam logic [lbas_pkg::SIZE_W-1:0] MAX_SIZE = lbas_pkg::SIZE_W'(MAX_ACCESS_BYTES);

	logic [lbas_pkg::SIZE_W-1:0] clamped;

	assign clamped   = (size > MAX_SIZE) ? MAX_SIZE : size;
	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full && (clamped != '0);

	always_comb begin
		push_data.thread  = thread;
		push_data.kind    = kind;
		push_data.address = address;
		push_data.size    = clamped;
	end

endmodule

@@ sv/lbas_queue.sv @@
// Short queue of clamped accesses between front and back.
// Depends on lbas_pkg.
module lbas_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lbas_pkg::access_t push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output lbas_pkg::access_t head,
	output logic [$clog2(lbas_pkg::QUEUE_DEPTH+1)-1:0] level
);

	localparam int unsigned D  = lbas_pkg::QUEUE_DEPTH;
	localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
	localparam int unsigned CW = $clog2(D + 1);

	lbas_pkg::access_t mem_q [D];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CW'(D));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign level     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/lbas_back.sv @@
// Back end: cuts one access at a time into pieces, one piece per cycle unless the
// output is stalled, into a result register. Depends on lbas_pkg.
module lbas_back #(
	parameter int unsigned LINE_BYTES = lbas_pkg::LINE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  lbas_pkg::access_t             head,
	output lbas_pkg::back_status_t        status,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [lbas_pkg::SEQ_W-1:0]    sequence_res,
	output logic [lbas_pkg::THREAD_W-1:0] thread_out,
	output logic                          kind_out,
	output logic [lbas_pkg::ADDR_W-1:0]   piece_address,
	output logic                          last
);

	localparam int unsigned LW = $clog2(LINE_BYTES);
	localparam logic [LW-1:0] NEAR_END = LW'(LINE_BYTES - 8);
	localparam int unsigned PW = lbas_pkg::PIECE_W;

	logic                          busy_q;
	logic [lbas_pkg::ADDR_W-1:0]   addr_q;
	logic [lbas_pkg::SIZE_W-1:0]   left_q;
	logic [lbas_pkg::THREAD_W-1:0] thread_q;
	logic                          kind_q;
	logic [lbas_pkg::SEQ_W-1:0]    piece_cnt_q;

	logic                          res_valid_q;
	logic [lbas_pkg::SEQ_W-1:0]    seq_q;
	logic [lbas_pkg::THREAD_W-1:0] thread_out_q;
	logic                          kind_out_q;
	logic [lbas_pkg::ADDR_W-1:0]   piece_addr_q;
	logic                          last_q;

	logic [LW-1:0]                 offset;
	logic [PW-1:0]                 room;
	logic [PW-1:0]                 lim;
	logic [PW-1:0]                 piece;
	logic [lbas_pkg::SIZE_W-1:0]   left_nx;
	logic                          fin;
	logic                          out_free;
	logic                          advance;
	logic                          pop;

	assign offset = addr_q[LW-1:0];
	assign room   = (offset >= NEAR_END) ? (PW'(8) - PW'(offset[2:0])) : PW'(8);
	assign lim    = (left_q < lbas_pkg::SIZE_W'(room)) ? left_q[PW-1:0] : room;

	always_comb begin
		if (lim[3]) begin
			piece = PW'(8);
		end else if (lim[2]) begin
			piece = PW'(4);
		end else if (lim[1]) begin
			piece = PW'(2);
		end else begin
			piece = PW'(1);
		end
	end

	assign left_nx  = left_q - lbas_pkg::SIZE_W'(piece);
	assign fin      = (left_nx == '0);
	assign out_free = !res_valid_q || !res_stall;
	assign advance  = busy_q && out_free;
	assign pop      = head_valid && (!busy_q || (advance && fin));

	always_comb begin
		status.busy = busy_q;
		status.pop  = pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			piece_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && fin) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				piece_cnt_q <= piece_cnt_q + lbas_pkg::SEQ_W'(1);
			end
			if (out_free) begin
				res_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q   <= head.address;
			left_q   <= head.size;
			thread_q <= head.thread;
			kind_q   <= head.kind;
		end else if (advance) begin
			addr_q <= addr_q + lbas_pkg::ADDR_W'(piece);
			left_q <= left_nx;
		end
		if (advance) begin
			seq_q        <= piece_cnt_q;
			thread_out_q <= thread_q;
			kind_out_q   <= kind_q;
			piece_addr_q <= addr_q;
			last_q       <= fin;
		end
	end

	assign res_valid     = res_valid_q;
	assign sequence_res  = seq_q;
	assign thread_out    = thread_out_q;
	assign kind_out      = kind_out_q;
	assign piece_address = piece_addr_q;
	assign last          = last_q;

endmodule

@@ tb/tb.sv @@
// Testbench for line_bounded_access_splitter: sends directed and random requests and checks
// every emitted piece against an in-bench splitter model, under random sender and receiver idling.
// Depends on lbas_pkg and the line_bounded_access_splitter RTL.
module tb;

	import lbas_pkg::*;

	localparam int unsigned LINE_SIZE  = LINE_BYTES_DEF;
	localparam int unsigned MAX_ACCESS = MAX_ACCESS_BYTES_DEF;
	localparam int unsigned MAX_PIECES = 16;

	typedef struct {
		logic [SEQ_W-1:0]    seq;
		logic [THREAD_W-1:0] thread;
		logic                knd;
		logic [ADDR_W-1:0]   addr;
		logic                is_last;
	} piece_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [THREAD_W-1:0] thread = '0;
	logic                kind = KIND_READ;
	logic [ADDR_W-1:0]   address = '0;
	logic [SIZE_W-1:0]   size = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [SEQ_W-1:0]    sequence_res;
	logic [THREAD_W-1:0] thread_out;
	logic                kind_out;
	logic [ADDR_W-1:0]   piece_address;
	logic                last;

	piece_t          pending_pieces[$];
	logic [SEQ_W-1:0] piece_count = '0;
	int              mismatches = 0;
	bit              sender_idles = 1'b1;
	int              burst_left = 0;
	int              stall_mode = 0;
	int              stall_hold = 0;

	line_bounded_access_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.thread(thread),
		.kind(kind),
		.address(address),
		.size(size),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sequence_res(sequence_res),
		.thread_out(thread_out),
		.kind_out(kind_out),
		.piece_address(piece_address),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void split_access(input logic [THREAD_W-1:0] tid, input logic knd,
			input logic [ADDR_W-1:0] start, input logic [SIZE_W-1:0] sz);
		longint unsigned left;
		longint unsigned room;
		longint unsigned step;
		logic [ADDR_W-1:0] addr;
		piece_t pc;
		int n;
		left = (sz > MAX_ACCESS) ? 64'(MAX_ACCESS) : 64'(sz);
		addr = start;
		n = 0;
		while (left > 0 && n < MAX_PIECES) begin
			room = 64'(LINE_SIZE) - (addr % 64'(LINE_SIZE));
			step = 8;
			while (step > 1 && (step > left || step > room))
				step = step >> 1;
			left = left - step;
			pc.seq = piece_count;
			pc.thread = tid;
			pc.knd = knd;
			pc.addr = addr;
			pc.is_last = (left == 0);
			pending_pieces.push_back(pc);
			piece_count = piece_count + 1;
			addr = addr + step;
			n++;
		end
	endfunction

	task automatic send_access(input logic [THREAD_W-1:0] tid, input logic knd,
			input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] sz);
		int gap;
		req_valid <= 1'b1;
		thread <= tid;
		kind <= knd;
		address <= addr;
		size <= sz;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		split_access(tid, knd, addr, sz);
		if (sender_idles) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 12);
				gap = $urandom_range(1, 7);
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// receiver stall pattern: none, light or heavy, chosen anew at random intervals
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_hold <= $urandom_range(20, 120);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			0: begin
				res_stall <= 1'b0;
			end
			1: begin
				res_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				res_stall <= ($urandom_range(0, 9) < 7);
			end
		endcase
	end

	always @(posedge clk) begin : check_piece
		piece_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pieces.size() == 0) begin
				$error("unexpected piece at address %0h", piece_address);
				mismatches++;
			end else begin
				want = pending_pieces.pop_front();
				if (sequence_res !== want.seq) begin
					$error("sequence_res: expected %0h, got %0h", want.seq, sequence_res);
					mismatches++;
				end
				if (thread_out !== want.thread) begin
					$error("thread_out: expected %0h, got %0h", want.thread, thread_out);
					mismatches++;
				end
				if (kind_out !== want.knd) begin
					$error("kind_out: expected %0h, got %0h", want.knd, kind_out);
					mismatches++;
				end
				if (piece_address !== want.addr) begin
					$error("piece_address: expected %0h, got %0h", want.addr, piece_address);
					mismatches++;
				end
				if (last !== want.is_last) begin
					$error("last: expected %0h, got %0h", want.is_last, last);
					mismatches++;
				end
			end
		end
	end

	task automatic test_edge_accesses();
		send_access(8'h00, KIND_READ, 64'h0, 7'd0);
		send_access(8'hFF, KIND_WRITE, 64'h0, 7'd1);
		send_access(8'h01, KIND_READ, 64'h0, 7'd64);
		send_access(8'h02, KIND_WRITE, 64'd61, 7'd8);
		send_access(8'h03, KIND_READ, 64'd3, 7'd13);
		send_access(8'h04, KIND_WRITE, 64'd7, 7'h7F);
		send_access(8'h05, KIND_READ, 64'd5, 7'd65);
		send_access(8'h06, KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
		send_access(8'h07, KIND_READ, 64'hFFFF_FFFF_FFFF_FFF8, 7'd16);
		send_access(8'h08, KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFC1, 7'd63);
		send_access(8'hAA, KIND_READ, 64'hAAAA_AAAA_AAAA_AAAA, 7'd2);
		send_access(8'h55, KIND_WRITE, 64'h5555_5555_5555_5555, 7'd3);
		send_access(8'h10, KIND_READ, 64'h0000_0000_0000_003F, 7'd4);
		send_access(8'h11, KIND_WRITE, 64'h1234_5678_9ABC_DEF0, 7'd5);
		send_access(8'h12, KIND_READ, 64'h8000_0000_0000_0039, 7'd6);
		send_access(8'h13, KIND_WRITE, 64'h0000_0000_0000_0021, 7'd7);
		send_access(8'h14, KIND_READ, 64'h0000_0000_0000_0040, 7'd9);
		send_access(8'h15, KIND_WRITE, 64'h0000_0000_0000_007E, 7'd0);
		send_access(8'h16, KIND_READ, 64'h0000_0000_0000_0001, 7'd64);
		send_access(8'h17, KIND_WRITE, 64'h7FFF_FFFF_FFFF_FFFC, 7'd40);
	endtask

	task automatic test_streaming_accesses(input int count);
		sender_idles = 1'b0;
		for (int i = 0; i < count; i++)
			send_access(THREAD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				{$urandom, $urandom}, SIZE_W'($urandom_range(33, 64)));
		sender_idles = 1'b1;
	endtask

	task automatic test_random_accesses(input int count);
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] sz;
		int pick;
		for (int i = 0; i < count; i++) begin
			addr = {$urandom, $urandom};
			pick = $urandom_range(0, 9);
			if (pick < 3)
				addr[5:0] = 6'($urandom_range(56, 63));
			else if (pick == 3)
				addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 70));
			pick = $urandom_range(0, 9);
			if (pick < 5)
				sz = SIZE_W'($urandom_range(1, 16));
			else if (pick < 8)
				sz = SIZE_W'($urandom_range(1, 64));
			else if (pick == 8)
				sz = SIZE_W'($urandom_range(65, 127));
			else
				sz = 7'd0;
			send_access(THREAD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), addr, sz);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_accesses();
		test_streaming_accesses(40);
		test_random_accesses(330);
		req_valid <= 1'b0;
		while (pending_pieces.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
sv/lbas_pkg.sv
sv/lbas_front.sv
sv/lbas_queue.sv
sv/lbas_back.sv
sv/line_bounded_access_splitter.sv
tb/tb.sv
